// ===== design/cro_alloc_pkg.sv =====
// Shared types and constants for the credit ring offset allocator.
`default_nettype none
package cro_alloc_pkg;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_RDY  = 2'd2,
    ST_PROGRESS = 2'd3
  } status_t;

  localparam logic KIND_ALLOC    = 1'b0;
  localparam logic KIND_PROGRESS = 1'b1;

  // Register indexes (word address paddr[3:2]).
  localparam logic [1:0] REG_RING_LOG2 = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_PEER_ID   = 2'd2;
  localparam logic [1:0] REG_EV_PREFIX = 2'd3;

  localparam logic [4:0]  RING_LOG2_RST = 5'd12;
  localparam logic [15:0] THRESHOLD_RST = 16'd3276;
  localparam int unsigned MIN_RING_LOG2 = 4;

  typedef struct packed {
    status_t     status;
    logic [15:0] offset;
    logic        fetch_request;
    logic [63:0] fetch_cookie;
  } result_t;

endpackage
`default_nettype wire

// ===== design/credit_ring_offset_allocator_core.sv =====
// Credit ring offset allocator: register port, allocation logic and output buffer.
//
// Usage: the input channel (in_valid/in_ready) carries allocate transactions
// (kind 0: alloc_size, min_contig) and progress transactions (kind 1:
// remote_progress). Each input transaction yields exactly one result on the
// output channel (out_valid/out_ready): status, offset, fetch_request and
// fetch_cookie.
// An accepted result is registered into the output register, or into the skid
// register when that holds an untaken result. Throughput: one transaction per
// cycle while in_ready is high; the state update is a single pass of 64-bit
// subtract/compare logic between the state registers. A two-entry output buffer
// (output register plus skid register) lets one more transaction be accepted
// while a result waits; in_ready drops only when both entries are occupied, and
// rises again once the receiver takes a result.
// Reset (rst, synchronous): write position, skip count, receiver position
// and fetch-pending flag clear to zero, registers take their reset values,
// and the output buffer empties.
// Configuration is an APB-style port, one register per 32-bit word; pready
// is always high and writes land in the access cycle.
`default_nettype none
module credit_ring_offset_allocator_core #(
  parameter int unsigned MAX_RING_LOG2 = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [16:0] alloc_size,
  input  wire logic [16:0] min_contig,
  input  wire logic [63:0] remote_progress,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  status,
  output logic      [15:0] offset,
  output logic             fetch_request,
  output logic      [63:0] fetch_cookie
);

  localparam int unsigned RW = MAX_RING_LOG2 + 1;

  // configuration registers
  logic [4:0]  ring_log2;
  logic [15:0] threshold;
  logic [31:0] peer_id;
  logic [31:0] cookie_prefix;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_log2     <= cro_alloc_pkg::RING_LOG2_RST;
      threshold     <= cro_alloc_pkg::THRESHOLD_RST;
      peer_id       <= '0;
      cookie_prefix <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cro_alloc_pkg::REG_RING_LOG2: ring_log2     <= pwdata[4:0];
        cro_alloc_pkg::REG_THRESHOLD: threshold     <= pwdata[15:0];
        cro_alloc_pkg::REG_PEER_ID:   peer_id       <= pwdata;
        cro_alloc_pkg::REG_EV_PREFIX: cookie_prefix <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cro_alloc_pkg::REG_RING_LOG2: prdata = {27'd0, ring_log2};
      cro_alloc_pkg::REG_THRESHOLD: prdata = {16'd0, threshold};
      cro_alloc_pkg::REG_PEER_ID:   prdata = peer_id;
      cro_alloc_pkg::REG_EV_PREFIX: prdata = cookie_prefix;
      default:                      prdata = '0;
    endcase
  end

  // allocator state
  logic [63:0] write_position, write_position_next;
  logic [63:0] skipped_bytes, skipped_bytes_next;
  logic [63:0] receiver_position, receiver_position_next;
  logic        fetch_pending, fetch_pending_next;

  logic [5:0]    lg_ext, lg_eff;
  logic [RW-1:0] ring_w, ring_o, ring_left;
  logic [63:0]   ring_64, used, outstanding;
  cro_alloc_pkg::result_t res;

  always_comb begin
    lg_ext = {1'b0, ring_log2};
    if (lg_ext < 6'(cro_alloc_pkg::MIN_RING_LOG2)) begin
      lg_eff = 6'(cro_alloc_pkg::MIN_RING_LOG2);
    end else if (lg_ext > 6'(MAX_RING_LOG2)) begin
      lg_eff = 6'(MAX_RING_LOG2);
    end else begin
      lg_eff = lg_ext;
    end
    ring_w    = RW'(1) << lg_eff;
    ring_o    = write_position[RW-1:0] & (ring_w - RW'(1));
    ring_left = ring_w - ring_o;
    ring_64   = 64'(ring_w);
    used        = write_position - skipped_bytes;
    outstanding = write_position - receiver_position;

    write_position_next    = write_position;
    skipped_bytes_next     = skipped_bytes;
    receiver_position_next = receiver_position;
    fetch_pending_next     = fetch_pending;
    res.status        = cro_alloc_pkg::ST_PROGRESS;
    res.offset        = '0;
    res.fetch_request = 1'b0;

    if (kind == cro_alloc_pkg::KIND_PROGRESS) begin
      receiver_position_next = remote_progress;
      fetch_pending_next     = 1'b0;
    end else if (used >= ring_64) begin
      res.status = cro_alloc_pkg::ST_FULL;
    end else if (outstanding + 64'(alloc_size) >= ring_64) begin
      res.status         = cro_alloc_pkg::ST_NOT_RDY;
      res.fetch_request  = !fetch_pending;
      fetch_pending_next = 1'b1;
    end else begin
      res.status = cro_alloc_pkg::ST_GRANTED;
      if (64'(ring_left) < 64'(min_contig)) begin
        // too little room before the ring end: skip to offset zero
        write_position_next = write_position + 64'(ring_left) + 64'(alloc_size);
        skipped_bytes_next  = skipped_bytes + 64'(ring_left);
      end else begin
        write_position_next = write_position + 64'(alloc_size);
        res.offset          = 16'(ring_o);
      end
      if (outstanding == 64'(threshold) && !fetch_pending) begin
        res.fetch_request  = 1'b1;
        fetch_pending_next = 1'b1;
      end
    end
    res.fetch_cookie = res.fetch_request ? {cookie_prefix, peer_id} : 64'd0;
  end

  // two-entry output buffer
  cro_alloc_pkg::result_t main_res, skid_res;
  logic main_valid, skid_valid;
  logic push, pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position    <= '0;
      skipped_bytes     <= '0;
      receiver_position <= '0;
      fetch_pending     <= 1'b0;
    end else if (push) begin
      write_position    <= write_position_next;
      skipped_bytes     <= skipped_bytes_next;
      receiver_position <= receiver_position_next;
      fetch_pending     <= fetch_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      main_valid <= 1'b1;
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign out_valid     = main_valid;
  assign status        = main_res.status;
  assign offset        = main_res.offset;
  assign fetch_request = main_res.fetch_request;
  assign fetch_cookie  = main_res.fetch_cookie;

endmodule
`default_nettype wire

// ===== design/cro_alloc_checker.sv =====
// Port-level checker for the credit ring offset allocator, with its bind.
`default_nettype none
module cro_alloc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] offset,
  input wire logic        fetch_request,
  input wire logic [63:0] fetch_cookie
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset)
      && $stable(fetch_request) && $stable(fetch_cookie))
    else $error("stalled result changed");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cro_alloc_pkg::ST_GRANTED |-> offset == 16'd0)
    else $error("nonzero offset without grant");

  a_cookie_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fetch_request |-> fetch_cookie == 64'd0)
    else $error("cookie without fetch request");

  a_no_fetch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cro_alloc_pkg::ST_PROGRESS || status == cro_alloc_pkg::ST_FULL)
      |-> !fetch_request)
    else $error("fetch request on full or progress result");

endmodule

bind credit_ring_offset_allocator_core cro_alloc_checker u_cro_alloc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .offset        (offset),
  .fetch_request (fetch_request),
  .fetch_cookie  (fetch_cookie)
);
`default_nettype wire
